FILE: rtl/core/rva_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rva_pkg
// Types, constants and the arctangent table of the axis rotation block.
// ----------------------------------------------------------------------------
package rva_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [17:0] ONE_Q15 = 18'sd32768;

  typedef logic signed [15:0] comp_t;

  typedef struct packed {
    comp_t vec_x;
    comp_t vec_y;
    comp_t vec_z;
    comp_t axis_x;
    comp_t axis_y;
    comp_t axis_z;
    comp_t turn_angle;
  } in_item_t;

  typedef struct packed {
    comp_t rot_x;
    comp_t rot_y;
    comp_t rot_z;
    logic  clipped;
  } out_item_t;

  // cordic state carried between stages
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } cordic_t;

  function automatic logic signed [33:0] atan_unit(input int idx);
    logic signed [33:0] a;
    case (idx)
      0:  a = 34'sh20000000;
      1:  a = 34'sh12E4051E;
      2:  a = 34'sh09FB385B;
      3:  a = 34'sh051111D4;
      4:  a = 34'sh028B0D43;
      5:  a = 34'sh0145D7E1;
      6:  a = 34'sh00A2F61E;
      7:  a = 34'sh00517C55;
      8:  a = 34'sh0028BE53;
      9:  a = 34'sh00145F2F;
      10: a = 34'sh000A2F98;
      11: a = 34'sh000517CC;
      12: a = 34'sh00028BE6;
      13: a = 34'sh000145F3;
      14: a = 34'sh0000A2FA;
      15: a = 34'sh0000517D;
      16: a = 34'sh000028BE;
      17: a = 34'sh0000145F;
      18: a = 34'sh00000A30;
      19: a = 34'sh00000518;
      20: a = 34'sh0000028C;
      21: a = 34'sh00000146;
      22: a = 34'sh000000A3;
      23: a = 34'sh00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rva_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rva_in_if / rva_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rva_in_if;
  logic              valid;
  logic              ready;
  rva_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rva_out_if;
  logic               valid;
  logic               ready;
  rva_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rotate_vector_about_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotate_vector_about_axis
// Rodrigues rotation of a Q2.13 vector about an axis by a binary angle.
// ----------------------------------------------------------------------------
//  channel   dir   beat
//  in_       in    vector, axis, angle
//  out_      out   rotated vector, clipped flag
//
//  one beat accepted every cycle while the last stage is empty or taken
//  the stages are the phase fold register, one register per cordic step
//  and five product stages
//  rst_n clears only the stage valid bits
//  the whole pipeline advances when the last stage is empty or taken;
//  a stall holds every stage in place
module rotate_vector_about_axis #(
  parameter int SINCOS_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rva_in_if.sink    in_ch,
  rva_out_if.source out_ch
);

  localparam int NST = SINCOS_STEPS + 6;

  logic [NST-1:0] vld_r;
  logic           adv;

  assign adv = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  // operands ride alongside the cordic
  rva_pkg::in_item_t side_r [SINCOS_STEPS+1];

  // stage 0: fold the phase into +-pi/2
  rva_pkg::cordic_t c0_r;
  rva_pkg::cordic_t cnxt;
  logic signed [33:0] ph;

  always_comb begin
    ph = {{2{in_ch.data.turn_angle[15]}}, in_ch.data.turn_angle, 16'h0};
    cnxt.x = rva_pkg::CORDIC_GAIN_Q30;
    cnxt.y = '0;
    cnxt.flip = 1'b0;
    cnxt.z = ph;
    if (ph > 34'sh40000000) begin
      cnxt.z = ph - 34'sh80000000;
      cnxt.flip = 1'b1;
    end else if (ph < -34'sh40000000) begin
      cnxt.z = ph + 34'sh80000000;
      cnxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_r <= cnxt;
      side_r[0] <= in_ch.data;
      for (int i = 1; i <= SINCOS_STEPS; i++) side_r[i] <= side_r[i-1];
    end
  end

  rva_pkg::cordic_t cs [SINCOS_STEPS+1];
  assign cs[0] = c0_r;

  for (genvar g = 0; g < SINCOS_STEPS; g++) begin : g_cordic
    rva_cordic_stage #(.STEP(g)) u_stage (
      .clk(clk), .en(adv), .d_in(cs[g]), .d_out(cs[g+1])
    );
  end

  // stage A: round sin/cos, cross and dot partial products
  rva_pkg::cordic_t cf;
  rva_pkg::in_item_t sd;
  logic signed [33:0] xr, yr;
  logic signed [17:0] s_nxt, c_nxt;
  assign cf = cs[SINCOS_STEPS];
  assign sd = side_r[SINCOS_STEPS];

  always_comb begin
    xr = (cf.x + 34'sd16384) >>> 15;
    yr = (cf.y + 34'sd16384) >>> 15;
    if (cf.flip) begin
      xr = -xr;
      yr = -yr;
    end
    if (xr > 34'sd32768) xr = 34'sd32768;
    if (xr < -34'sd32768) xr = -34'sd32768;
    if (yr > 34'sd32768) yr = 34'sd32768;
    if (yr < -34'sd32768) yr = -34'sd32768;
    c_nxt = xr[17:0];
    s_nxt = yr[17:0];
  end

  logic signed [17:0] sa_r, ca_r;
  logic signed [31:0] pa_r [9];
  rva_pkg::comp_t va_r [3];
  rva_pkg::comp_t ka_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r <= s_nxt;
      ca_r <= c_nxt;
      va_r[0] <= sd.vec_x;  va_r[1] <= sd.vec_y;  va_r[2] <= sd.vec_z;
      ka_r[0] <= sd.axis_x; ka_r[1] <= sd.axis_y; ka_r[2] <= sd.axis_z;
      pa_r[0] <= sd.axis_y * sd.vec_z;
      pa_r[1] <= sd.axis_z * sd.vec_y;
      pa_r[2] <= sd.axis_z * sd.vec_x;
      pa_r[3] <= sd.axis_x * sd.vec_z;
      pa_r[4] <= sd.axis_x * sd.vec_y;
      pa_r[5] <= sd.axis_y * sd.vec_x;
      pa_r[6] <= sd.axis_x * sd.vec_x;
      pa_r[7] <= sd.axis_y * sd.vec_y;
      pa_r[8] <= sd.axis_z * sd.vec_z;
    end
  end

  // stage B: cross and dot sums, v*cos
  logic signed [17:0] sb_r, omcb_r;
  logic signed [32:0] crb_r [3];
  logic signed [33:0] dotb_r;
  logic signed [33:0] vcb_r [3];
  rva_pkg::comp_t kb_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r <= sa_r;
      omcb_r <= rva_pkg::ONE_Q15 - ca_r;
      crb_r[0] <= 33'(pa_r[0]) - 33'(pa_r[1]);
      crb_r[1] <= 33'(pa_r[2]) - 33'(pa_r[3]);
      crb_r[2] <= 33'(pa_r[4]) - 33'(pa_r[5]);
      dotb_r <= 34'(pa_r[6]) + 34'(pa_r[7]) + 34'(pa_r[8]);
      for (int j = 0; j < 3; j++) begin
        vcb_r[j] <= 34'(va_r[j]) * 34'(ca_r);
        kb_r[j] <= ka_r[j];
      end
    end
  end

  // stage C: k*dot, cross*sin
  logic signed [17:0] omcc_r;
  logic signed [50:0] crsc_r [3];
  logic signed [49:0] kdc_r [3];
  logic signed [33:0] vcc_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      omcc_r <= omcb_r;
      for (int j = 0; j < 3; j++) begin
        crsc_r[j] <= 51'(crb_r[j]) * 51'(sb_r);
        kdc_r[j] <= 50'(kb_r[j]) * 50'(dotb_r);
        vcc_r[j] <= vcb_r[j];
      end
    end
  end

  // stage D: round along term, times (1 - cos)
  logic signed [36:0] alg [3];
  logic signed [54:0] almd_r [3];
  logic signed [50:0] crsd_r [3];
  logic signed [33:0] vcd_r [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      alg[j] = 37'((kdc_r[j] + 50'sd4096) >>> 13);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        almd_r[j] <= 55'(alg[j]) * 55'(omcc_r);
        crsd_r[j] <= crsc_r[j];
        vcd_r[j] <= vcc_r[j];
      end
    end
  end

  // stage E: sum in Q41, round and saturate
  logic signed [56:0] acc [3];
  logic signed [28:0] rr [3];
  logic [2:0] clp;
  rva_pkg::comp_t re [3];
  rva_pkg::out_item_t out_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc[j] = (57'(vcd_r[j]) <<< 13) + 57'(crsd_r[j]) + 57'(almd_r[j]) + 57'sh8000000;
      rr[j] = acc[j][56:28];
      clp[j] = 1'b0;
      re[j] = rr[j][15:0];
      if (rr[j] > 29'sd32767) begin
        re[j] = 16'sh7FFF;
        clp[j] = 1'b1;
      end else if (rr[j] < -29'sd32768) begin
        re[j] = 16'sh8000;
        clp[j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.rot_x <= re[0];
      out_r.rot_y <= re[1];
      out_r.rot_z <= re[2];
      out_r.clipped <= |clp;
    end
  end

  assign out_ch.valid = vld_r[NST-1];
  assign out_ch.data = out_r;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready && !in_ch.valid && !out_ch.valid |=> !vld_r[0])
    else $error("bubble gained a valid bit");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/rva_cordic_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rva_cordic_stage
// One registered cordic micro-rotation, enabled by the pipeline advance.
// ----------------------------------------------------------------------------
module rva_cordic_stage #(
  parameter int STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire rva_pkg::cordic_t d_in,
  output rva_pkg::cordic_t      d_out
);

  rva_pkg::cordic_t d_nxt;
  rva_pkg::cordic_t d_r;

  always_comb begin
    d_nxt = d_in;
    if (STEP < rva_pkg::ATAN_ENTRIES) begin
      if (!d_in.z[33]) begin
        d_nxt.x = d_in.x - (d_in.y >>> STEP);
        d_nxt.y = d_in.y + (d_in.x >>> STEP);
        d_nxt.z = d_in.z - rva_pkg::atan_unit(STEP);
      end else begin
        d_nxt.x = d_in.x + (d_in.y >>> STEP);
        d_nxt.y = d_in.y - (d_in.x >>> STEP);
        d_nxt.z = d_in.z + rva_pkg::atan_unit(STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule
`default_nettype wire

FILE: verif/rva_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rva_checker
// Watches the input and result channels of the axis rotation block, works
// out each rotated vector and compares it with what the block returns.
// ----------------------------------------------------------------------------
module rva_checker #(
  parameter int SINCOS_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  rva_pkg::in_item_t       in_data,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  rva_pkg::out_item_t      out_data,
  output int                      fail_count,
  output int                      pending
);

  rva_pkg::out_item_t rotated_q[$];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint t[24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
    return t[i];
  endfunction

  function automatic rva_pkg::out_item_t rotate_vector(rva_pkg::in_item_t it);
    longint v[3], k[3], cr[3], ph, x, y, dx, dy, sn, cs, omc, dot, along, acc, r;
    logic flip;
    rva_pkg::out_item_t res;
    v[0] = it.vec_x; v[1] = it.vec_y; v[2] = it.vec_z;
    k[0] = it.axis_x; k[1] = it.axis_y; k[2] = it.axis_z;
    ph = longint'(it.turn_angle) * 65536;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (ph > (64'sd1 <<< 30)) begin
      ph -= 64'sd1 <<< 31; flip = 1'b1;
    end else if (ph < -(64'sd1 <<< 30)) begin
      ph += 64'sd1 <<< 31; flip = 1'b1;
    end
    for (int i = 0; i < SINCOS_STEPS && i < 24; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (ph >= 0) begin
        x -= dx; y += dy; ph -= atan_step(i);
      end else begin
        x += dx; y -= dy; ph += atan_step(i);
      end
    end
    cs = rshift(x, 15);
    sn = rshift(y, 15);
    if (flip) begin
      cs = -cs; sn = -sn;
    end
    if (cs > 32768) cs = 32768;
    if (cs < -32768) cs = -32768;
    if (sn > 32768) sn = 32768;
    if (sn < -32768) sn = -32768;
    omc = 32768 - cs;
    cr[0] = k[1] * v[2] - k[2] * v[1];
    cr[1] = k[2] * v[0] - k[0] * v[2];
    cr[2] = k[0] * v[1] - k[1] * v[0];
    dot = k[0] * v[0] + k[1] * v[1] + k[2] * v[2];
    res.clipped = 1'b0;
    for (int j = 0; j < 3; j++) begin
      along = rshift(k[j] * dot, 13);
      acc = v[j] * cs * 8192 + cr[j] * sn + along * omc;
      r = rshift(acc, 28);
      if (r > 32767) begin
        r = 32767; res.clipped = 1'b1;
      end else if (r < -32768) begin
        r = -32768; res.clipped = 1'b1;
      end
      if (j == 0) res.rot_x = rva_pkg::comp_t'(r);
      else if (j == 1) res.rot_y = rva_pkg::comp_t'(r);
      else res.rot_z = rva_pkg::comp_t'(r);
    end
    return res;
  endfunction

  initial fail_count = 0;
  assign pending = rotated_q.size();

  always @(posedge clk) begin
    rva_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) rotated_q.push_back(rotate_vector(in_data));
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = rotated_q.pop_front();
          if (want.rot_x !== out_data.rot_x || want.rot_y !== out_data.rot_y ||
              want.rot_z !== out_data.rot_z || want.clipped !== out_data.clipped) begin
            $display("%0t: mismatch, expected %0d %0d %0d c%b, actual %0d %0d %0d c%b",
                     $time, want.rot_x, want.rot_y, want.rot_z, want.clipped,
                     out_data.rot_x, out_data.rot_y, out_data.rot_z, out_data.clipped);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

FILE: verif/rotate_vector_about_axis_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotate_vector_about_axis_test
// Drives directed and random rotations with random idling on both channels;
// a checker beside the block predicts every rotated vector.
// ----------------------------------------------------------------------------
module rotate_vector_about_axis_test;

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 6;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic calm = 1'b0;
  int   cycles = 0;
  int   fail_count;
  int   pending;

  rva_in_if  in_ch ();
  rva_out_if out_ch ();

  rotate_vector_about_axis #(.SINCOS_STEPS(STEPS)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  rva_checker #(.SINCOS_STEPS(STEPS)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side stalls in bursts
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 15);
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  function automatic rva_pkg::comp_t pick_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return rva_pkg::comp_t'($urandom_range(0, 16384) - 8192);
      default: return rva_pkg::comp_t'($urandom);
    endcase
  endfunction

  function automatic rva_pkg::in_item_t random_item();
    rva_pkg::in_item_t it;
    int u;
    it.vec_x = pick_comp();
    it.vec_y = pick_comp();
    it.vec_z = pick_comp();
    u = $urandom_range(0, 3);
    if (u < 3) begin
      // mostly a near-unit axis
      it.axis_x = (u == 0) ? 16'sd8192 : rva_pkg::comp_t'($urandom_range(0, 9000) - 4500);
      it.axis_y = (u == 1) ? -16'sd8192 : rva_pkg::comp_t'($urandom_range(0, 9000) - 4500);
      it.axis_z = (u == 2) ? 16'sd8192 : rva_pkg::comp_t'($urandom_range(0, 9000) - 4500);
    end else begin
      it.axis_x = pick_comp();
      it.axis_y = pick_comp();
      it.axis_z = pick_comp();
    end
    it.turn_angle = rva_pkg::comp_t'($urandom);
    return it;
  endfunction

  task automatic send_beat(input rva_pkg::in_item_t it);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rva_pkg::in_item_t it;
    rva_pkg::comp_t angles[8] = '{16'sh0000, 16'sh4000, 16'shC000, 16'sh8000,
                                  16'sh7FFF, 16'sh2000, 16'sh4001, 16'shBFFF};
    int wait_n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // extremes and special angles
    foreach (angles[i]) begin
      it = '{vec_x: 16'sd8192, vec_y: 16'sd4096, vec_z: -16'sd2048,
             axis_x: 16'sd0, axis_y: 16'sd0, axis_z: 16'sd8192,
             turn_angle: angles[i]};
      send_beat(it);
    end
    for (int i = 0; i < 6; i++) begin
      it.vec_x = (i & 1) ? 16'sh7FFF : 16'sh8000;
      it.vec_y = (i & 2) ? 16'sh7FFF : 16'sh8000;
      it.vec_z = (i & 4) ? 16'sh8000 : 16'sh7FFF;
      it.axis_x = (i < 3) ? 16'sh7FFF : 16'sh8000;
      it.axis_y = (i == 2) ? 16'sh8000 : 16'sh7FFF;
      it.axis_z = 16'sh8000;
      it.turn_angle = angles[i];
      send_beat(it);
    end
    it = '{default: 16'sh0000};
    send_beat(it);
    it = '{vec_x: 16'sh7FFF, vec_y: 16'sh7FFF, vec_z: 16'sh7FFF,
           axis_x: 16'sd4730, axis_y: 16'sd4730, axis_z: 16'sd4730,
           turn_angle: 16'sh8000};
    send_beat(it);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 200) calm = 1'b1;
      send_beat(random_item());
    end
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    wait_n = 0;
    while (wait_n < 4 * LATENCY) begin
      @(posedge clk);
      wait_n++;
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
